// ===== rtl/core/rau_pkg.sv =====
// rau_pkg: shared widths, codes and types of the rational arithmetic unit
`default_nettype none
package rau_pkg;

    // operand field width
    localparam int OPERAND_WIDTH = 16;
    // a reduced operand such as -32768/-1 needs one more bit
    localparam int RED_W   = OPERAND_WIDTH + 1;
    // result fields
    localparam int RES_W   = 32;
    // euclid and divider datapath: holds +2^31 after a quotient by -1
    localparam int DIV_W   = RES_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    // product widths
    localparam int PROD_W  = 2 * RED_W;
    localparam int MUL_W   = (PROD_W > RES_W) ? PROD_W : RES_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_TEST,
        S_GCD_WAIT,
        S_DIVN,
        S_DIVN_WAIT,
        S_DIVD,
        S_DIVD_WAIT,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_OUT
    } t_state;

    // which pair is under reduction
    typedef enum logic [1:0] {
        STG_A,
        STG_B,
        STG_R
    } t_stage;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_W-1:0]  dividend;
        logic signed [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_W-1:0]  quot;
        logic signed [DIV_W-1:0]  rem;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/core/rau_if.sv =====
// rau_if: valid/ready channel interfaces for operand and result beats
`default_nettype none
interface rau_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              op;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_num;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_den;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_num;
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_den;

    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [rau_pkg::RES_W-1:0] res_num;
    logic signed [rau_pkg::RES_W-1:0] res_den;
    logic                             bad_gcd;

    modport source (output valid, res_num, res_den, bad_gcd, input ready);
    modport sink   (input valid, res_num, res_den, bad_gcd, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rau_divider.sv =====
// rau_divider: radix-2 signed divider with truncating quotient and remainder
`default_nettype none
module rau_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_rsp      o_rsp
);

    localparam int DW = rau_pkg::DIV_W;

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [rau_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [DW-1:0]                   r_q, n_q;
    logic [DW-1:0]                   r_r, n_r;
    logic [DW-1:0]                   r_d, n_d;
    logic                            r_qneg, n_qneg;
    logic                            r_rneg, n_rneg;

    logic [DW-1:0]                   w_abs_n, w_abs_d;
    logic [DW:0]                     w_shift, w_diff;

    // magnitudes of the operands
    assign w_abs_n = i_req.dividend[DW-1] ? DW'(-i_req.dividend) : DW'(i_req.dividend);
    assign w_abs_d = i_req.divisor[DW-1]  ? DW'(-i_req.divisor)  : DW'(i_req.divisor);

    // one restoring step
    assign w_shift = {r_r, r_q[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        n_qneg = r_qneg;
        n_rneg = r_rneg;
        if (r_busy) begin
            if (!w_diff[DW]) begin
                n_r = w_diff[DW-1:0];
                n_q = {r_q[DW-2:0], 1'b1};
            end else begin
                n_r = w_shift[DW-1:0];
                n_q = {r_q[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - rau_pkg::DIV_CNT_W'(1);
            if (r_cnt == rau_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = rau_pkg::DIV_CNT_W'(DW);
            n_q    = w_abs_n;
            n_r    = '0;
            n_d    = w_abs_d;
            // quotient rounds toward zero, remainder follows the dividend
            n_qneg = i_req.dividend[DW-1] ^ i_req.divisor[DW-1];
            n_rneg = i_req.dividend[DW-1];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_r    <= n_r;
        r_d    <= n_d;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

    // signed results
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_qneg ? -signed'(r_q) : signed'(r_q);
    assign o_rsp.rem  = r_rneg ? -signed'(r_r) : signed'(r_r);

endmodule
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: reduced add, subtract, multiply and divide of two fractions
//
//   channel  dir  handshake     payload
//   i_in     in   valid/ready   op, a_num, a_den, b_num, b_den
//   o_out    out  valid/ready   res_num, res_den, bad_gcd
//
// one item at a time: i_in.ready is high only while the unit is idle
// every remainder and every reduction quotient comes from the shared divider
// cross products take turns on one shared multiplier
// the result beat is held on o_out until taken; synchronous active-low reset to idle
`default_nettype none
module rational_arithmetic_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rau_in_if.sink     i_in,
    rau_out_if.source  o_out
);

    localparam int W  = rau_pkg::OPERAND_WIDTH;
    localparam int RW = rau_pkg::RED_W;
    localparam int DW = rau_pkg::DIV_W;
    localparam int OW = rau_pkg::RES_W;

    rau_pkg::t_state  r_state, n_state;
    rau_pkg::t_stage  r_stage, n_stage;
    logic             r_bad, n_bad;

    rau_pkg::t_op             r_op, n_op;
    logic signed [W-1:0]      r_bn_in, n_bn_in;
    logic signed [W-1:0]      r_bd_in, n_bd_in;
    logic signed [DW-1:0]     r_x, n_x;
    logic signed [DW-1:0]     r_y, n_y;
    logic signed [DW-1:0]     r_n, n_n;
    logic signed [DW-1:0]     r_d, n_d;
    logic signed [DW-1:0]     r_g, n_g;
    logic signed [RW-1:0]     r_an, n_an;
    logic signed [RW-1:0]     r_ad, n_ad;
    logic signed [RW-1:0]     r_bn, n_bn;
    logic signed [RW-1:0]     r_bd, n_bd;
    logic signed [OW-1:0]     r_prod, n_prod;
    logic signed [OW-1:0]     r_acc, n_acc;

    rau_pkg::t_div_req        div_req;
    rau_pkg::t_div_rsp        div_rsp;

    logic signed [RW-1:0]                 m_a, m_b;
    logic signed [rau_pkg::PROD_W-1:0]    w_prod_full;
    logic signed [rau_pkg::MUL_W-1:0]     w_prod_ext;
    logic signed [OW-1:0]                 w_prod;
    logic signed [OW-1:0]                 w_sum;

    // shared divider for remainders and reductions
    rau_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // multiplier operand select
    always_comb begin
        case (r_state)
            rau_pkg::S_MUL_A: begin
                m_a = r_an;
                m_b = (r_op == rau_pkg::OP_MUL) ? r_bn : r_bd;
            end
            rau_pkg::S_MUL_B: begin
                m_a = r_bn;
                m_b = r_ad;
            end
            rau_pkg::S_MUL_C: begin
                m_a = r_ad;
                m_b = (r_op == rau_pkg::OP_DIV) ? r_bn : r_bd;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // product wraps to the result width
    assign w_prod_full = rau_pkg::PROD_W'(m_a) * rau_pkg::PROD_W'(m_b);
    assign w_prod_ext  = rau_pkg::MUL_W'(w_prod_full);
    assign w_prod      = w_prod_ext[OW-1:0];

    // numerator combine
    always_comb begin
        unique case (r_op) inside
            rau_pkg::OP_ADD:                 w_sum = r_acc + r_prod;
            rau_pkg::OP_SUB:                 w_sum = r_acc - r_prod;
            rau_pkg::OP_MUL, rau_pkg::OP_DIV: w_sum = r_acc;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        n_bad   = r_bad;
        n_op    = r_op;
        n_bn_in = r_bn_in;
        n_bd_in = r_bd_in;
        n_x     = r_x;
        n_y     = r_y;
        n_n     = r_n;
        n_d     = r_d;
        n_g     = r_g;
        n_an    = r_an;
        n_ad    = r_ad;
        n_bn    = r_bn;
        n_bd    = r_bd;
        n_prod  = r_prod;
        n_acc   = r_acc;
        div_req = '0;
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = rau_pkg::t_op'(i_in.op);
                    n_x     = DW'(i_in.a_num);
                    n_y     = DW'(i_in.a_den);
                    n_n     = DW'(i_in.a_num);
                    n_d     = DW'(i_in.a_den);
                    n_bn_in = i_in.b_num;
                    n_bd_in = i_in.b_den;
                    n_stage = rau_pkg::STG_A;
                    n_bad   = 1'b0;
                    n_state = rau_pkg::S_GCD_TEST;
                end
            end
            // euclid: stop when the divisor reaches zero
            rau_pkg::S_GCD_TEST: begin
                if (r_y == '0) begin
                    n_g = r_x;
                    if (r_x == '0) begin
                        n_bad   = 1'b1;
                        n_state = rau_pkg::S_OUT;
                    end else begin
                        n_state = rau_pkg::S_DIVN;
                    end
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_x;
                    div_req.divisor  = r_y;
                    n_state          = rau_pkg::S_GCD_WAIT;
                end
            end
            rau_pkg::S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    n_x     = r_y;
                    n_y     = div_rsp.rem;
                    n_state = rau_pkg::S_GCD_TEST;
                end
            end
            // numerator over gcd
            rau_pkg::S_DIVN: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_n;
                div_req.divisor  = r_g;
                n_state          = rau_pkg::S_DIVN_WAIT;
            end
            rau_pkg::S_DIVN_WAIT: begin
                if (div_rsp.done) begin
                    n_n     = div_rsp.quot;
                    n_state = rau_pkg::S_DIVD;
                end
            end
            // denominator over gcd
            rau_pkg::S_DIVD: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_d;
                div_req.divisor  = r_g;
                n_state          = rau_pkg::S_DIVD_WAIT;
            end
            rau_pkg::S_DIVD_WAIT: begin
                if (div_rsp.done) begin
                    n_d = div_rsp.quot;
                    unique case (r_stage)
                        rau_pkg::STG_A: begin
                            n_an    = r_n[RW-1:0];
                            n_ad    = div_rsp.quot[RW-1:0];
                            n_n     = DW'(r_bn_in);
                            n_d     = DW'(r_bd_in);
                            n_x     = DW'(r_bn_in);
                            n_y     = DW'(r_bd_in);
                            n_stage = rau_pkg::STG_B;
                            n_state = rau_pkg::S_GCD_TEST;
                        end
                        rau_pkg::STG_B: begin
                            n_bn    = r_n[RW-1:0];
                            n_bd    = div_rsp.quot[RW-1:0];
                            n_state = rau_pkg::S_MUL_A;
                        end
                        rau_pkg::STG_R: begin
                            n_state = rau_pkg::S_OUT;
                        end
                        default: begin
                            n_state = rau_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            // cross products, one per cycle
            rau_pkg::S_MUL_A: begin
                n_prod  = w_prod;
                n_state = rau_pkg::S_MUL_B;
            end
            rau_pkg::S_MUL_B: begin
                n_acc   = r_prod;
                n_prod  = w_prod;
                n_state = rau_pkg::S_MUL_C;
            end
            rau_pkg::S_MUL_C: begin
                n_n     = DW'(w_sum);
                n_prod  = w_prod;
                n_state = rau_pkg::S_MUL_D;
            end
            rau_pkg::S_MUL_D: begin
                n_d     = DW'(r_prod);
                n_x     = r_n;
                n_y     = DW'(r_prod);
                n_stage = rau_pkg::STG_R;
                n_state = rau_pkg::S_GCD_TEST;
            end
            rau_pkg::S_OUT: begin
                if (o_out.ready) begin
                    n_state = rau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            r_stage <= rau_pkg::STG_A;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_bad   <= n_bad;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_bn_in <= n_bn_in;
        r_bd_in <= n_bd_in;
        r_x     <= n_x;
        r_y     <= n_y;
        r_n     <= n_n;
        r_d     <= n_d;
        r_g     <= n_g;
        r_an    <= n_an;
        r_ad    <= n_ad;
        r_bn    <= n_bn;
        r_bd    <= n_bd;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
    end

    // channel outputs
    assign i_in.ready    = (r_state == rau_pkg::S_IDLE);
    assign o_out.valid   = (r_state == rau_pkg::S_OUT);
    assign o_out.res_num = r_bad ? '0 : r_n[OW-1:0];
    assign o_out.res_den = r_bad ? '0 : r_d[OW-1:0];
    assign o_out.bad_gcd = r_bad;

    // accepting a beat closes the input until the result is taken
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input still ready after an accepted beat");

    // input and output sides never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result beat is pending");

    // divider answers only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == rau_pkg::S_GCD_WAIT ||
                          r_state == rau_pkg::S_DIVN_WAIT ||
                          r_state == rau_pkg::S_DIVD_WAIT))
        else $error("divider finished outside a wait state");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// testbench: checks reduced fraction results of the rational arithmetic unit against a predictor
`default_nettype none
module testbench;

    // run bounds
    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int HOLD_CYCLES  = 10_000;
    localparam int TAIL_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 300;

    typedef logic signed [rau_pkg::OPERAND_WIDTH-1:0] t_opnd;

    typedef struct packed {
        logic signed [rau_pkg::RES_W-1:0] num;
        logic signed [rau_pkg::RES_W-1:0] den;
        logic                             bad;
    } t_frac;

    logic i_clk;
    logic i_rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // fractions still owed by the unit, oldest first
    t_frac pending_fractions[$];
    t_frac oldest;
    int    mismatches = 0;

    // sender burst state
    int burst_left = 0;

    // receiver hold-off requests and stall pattern
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_phase  = 0;

    t_opnd corner_vals [8] = '{0, 1, -1, 2, -2, 32767, -32767, -32768};

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // low 32 bits, sign extended
    function automatic longint wrap32(longint v);
        return longint'(int'(v));
    endfunction

    // divide a pair by its truncating-remainder gcd; 0 when that gcd is zero
    function automatic bit cut_by_gcd(inout longint n, inout longint d);
        longint x;
        longint y;
        longint t;
        x = n;
        y = d;
        while (y != 0) begin
            t = y;
            y = x % y;
            x = t;
        end
        if (x == 0)
            return 1'b0;
        n = n / x;
        d = d / x;
        return 1'b1;
    endfunction

    // expected reduced result of one operand beat
    function automatic t_frac calc_fraction(rau_pkg::t_op op, t_opnd an_i, t_opnd ad_i,
                                            t_opnd bn_i, t_opnd bd_i);
        longint an;
        longint ad;
        longint bn;
        longint bd;
        longint rn;
        longint rd;
        bit     ok_a;
        bit     ok_b;
        bit     ok;
        t_frac  r;
        an = longint'(an_i);
        ad = longint'(ad_i);
        bn = longint'(bn_i);
        bd = longint'(bd_i);
        rn = 0;
        rd = 0;
        ok_a = cut_by_gcd(an, ad);
        ok_b = cut_by_gcd(bn, bd);
        ok = ok_a && ok_b;
        if (ok) begin
            case (op)
                rau_pkg::OP_ADD: begin
                    rn = wrap32(wrap32(an * bd) + wrap32(bn * ad));
                    rd = wrap32(ad * bd);
                end
                rau_pkg::OP_SUB: begin
                    rn = wrap32(wrap32(an * bd) - wrap32(bn * ad));
                    rd = wrap32(ad * bd);
                end
                rau_pkg::OP_MUL: begin
                    rn = wrap32(an * bn);
                    rd = wrap32(ad * bd);
                end
                default: begin
                    rn = wrap32(an * bd);
                    rd = wrap32(ad * bn);
                end
            endcase
            ok = cut_by_gcd(rn, rd);
        end
        if (!ok) begin
            rn = 0;
            rd = 0;
        end
        r.num = rn[rau_pkg::RES_W-1:0];
        r.den = rd[rau_pkg::RES_W-1:0];
        r.bad = !ok;
        return r;
    endfunction

    // one random fraction: corners, small values, shared factors or full range
    function automatic void pick_fraction(output t_opnd n, output t_opnd d);
        int f;
        int t;
        case ($urandom_range(0, 7))
            0: begin
                n = corner_vals[$urandom_range(0, 7)];
                d = corner_vals[$urandom_range(0, 7)];
            end
            1: begin
                t = $urandom_range(0, 40);
                n = t_opnd'(t - 20);
                t = $urandom_range(0, 40);
                d = t_opnd'(t - 20);
            end
            2, 3: begin
                f = $urandom_range(2, 99);
                t = $urandom_range(0, 300);
                n = t_opnd'(($urandom_range(0, 1) == 1) ? -(f * t) : f * t);
                t = $urandom_range(0, 300);
                d = t_opnd'(($urandom_range(0, 1) == 1) ? -(f * t) : f * t);
            end
            default: begin
                n = t_opnd'($urandom);
                d = t_opnd'($urandom);
            end
        endcase
    endfunction

    // offer one operand beat, entered and left at a falling edge
    task automatic send_operands(rau_pkg::t_op op, t_opnd an, t_opnd ad,
                                 t_opnd bn, t_opnd bd);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                4, 5, 6:    gap = $urandom_range(1, 3);
                7, 8:       gap = $urandom_range(4, 60);
                default:    gap = $urandom_range(200, 2500);
            endcase
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_ch.op    = op;
        in_ch.a_num = an;
        in_ch.a_den = ad;
        in_ch.b_num = bn;
        in_ch.b_den = bd;
        in_ch.valid = 1'b1;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        pending_fractions.push_back(calc_fraction(op, an, ad, bn, bd));
        @(negedge i_clk);
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_fractions.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_each_op();
        send_operands(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_operands(rau_pkg::OP_SUB, 1, 2, 1, 3);
        send_operands(rau_pkg::OP_MUL, 2, 3, 3, 4);
        send_operands(rau_pkg::OP_DIV, 2, 3, 4, 5);
    endtask

    // 0/0 operands and a 0/0 result
    task automatic test_zero_gcd();
        send_operands(rau_pkg::OP_ADD, 0, 0, 3, 7);
        send_operands(rau_pkg::OP_DIV, 5, 9, 0, 0);
        send_operands(rau_pkg::OP_MUL, 0, 1, 1, 0);
    endtask

    // nonzero over zero reduces to a unit over zero
    task automatic test_zero_den();
        send_operands(rau_pkg::OP_DIV, 5, 0, 1, 1);
        send_operands(rau_pkg::OP_ADD, -7, 0, 2, 3);
        send_operands(rau_pkg::OP_SUB, 4, 6, -9, 0);
    endtask

    // negative gcd flips the signs of both numerator and denominator
    task automatic test_sign_moves();
        send_operands(rau_pkg::OP_ADD, 3, -6, -4, 6);
        send_operands(rau_pkg::OP_DIV, -12, 18, 10, -15);
    endtask

    // field extremes, the extra reduced bit and products near 2^31
    task automatic test_extremes();
        send_operands(rau_pkg::OP_MUL, -32768, -1, -32768, -1);
        send_operands(rau_pkg::OP_SUB, -32768, -32767, 32767, -32768);
        send_operands(rau_pkg::OP_ADD, -32768, -32767, -32767, -32768);
        send_operands(rau_pkg::OP_DIV, 32767, 32767, -32768, -32768);
        send_operands(rau_pkg::OP_SUB, -32768, 32767, -32768, -32767);
        send_operands(rau_pkg::OP_ADD, 32767, -32768, 32767, -32768);
        send_operands(rau_pkg::OP_MUL, -32767, 1, 32767, -1);
    endtask

    // receiver holds off long while operand beats keep coming
    task automatic test_backpressure();
        t_opnd an;
        t_opnd ad;
        t_opnd bn;
        t_opnd bd;
        hold_reqs++;
        burst_left = 10;
        repeat (4) begin
            pick_fraction(an, ad);
            pick_fraction(bn, bd);
            send_operands(rau_pkg::t_op'($urandom_range(0, 3)), an, ad, bn, bd);
        end
    endtask

    // sender pauses until the unit has handed back everything
    task automatic test_drain_pause();
        t_opnd an;
        t_opnd ad;
        t_opnd bn;
        t_opnd bd;
        repeat (2) begin
            repeat (3) begin
                pick_fraction(an, ad);
                pick_fraction(bn, bd);
                send_operands(rau_pkg::t_op'($urandom_range(0, 3)), an, ad, bn, bd);
            end
            wait_drained();
        end
    endtask

    task automatic test_random();
        t_opnd an;
        t_opnd ad;
        t_opnd bn;
        t_opnd bd;
        repeat (RANDOM_ITEMS) begin
            pick_fraction(an, ad);
            pick_fraction(bn, bd);
            send_operands(rau_pkg::t_op'($urandom_range(0, 3)), an, ad, bn, bd);
        end
    endtask

    // stimulus sequence
    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op    = rau_pkg::OP_ADD;
        in_ch.a_num = '0;
        in_ch.a_den = '0;
        in_ch.b_num = '0;
        in_ch.b_den = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_each_op();
        test_zero_gcd();
        test_zero_den();
        test_sign_moves();
        test_extremes();
        test_backpressure();
        test_drain_pause();
        test_random();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result receiver: long hold-offs on request, otherwise a changing stall pattern
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(1, 300);
                end
                rx_left--;
                rx_phase++;
                case (rx_mode)
                    0:       out_ch.ready = 1'b1;
                    1:       out_ch.ready = ($urandom_range(0, 1) == 1);
                    2:       out_ch.ready = ($urandom_range(0, 7) == 0);
                    default: out_ch.ready = ((rx_phase % 11) < 3);
                endcase
            end
        end
    end

    // result checker: each beat against the oldest owed fraction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_fractions.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, got %0d/%0d bad_gcd %0b",
                         $time, out_ch.res_num, out_ch.res_den, out_ch.bad_gcd);
            end else begin
                oldest = pending_fractions.pop_front();
                if (out_ch.res_num !== oldest.num) begin
                    mismatches++;
                    $display("%0t: res_num expected %0d got %0d",
                             $time, oldest.num, out_ch.res_num);
                end
                if (out_ch.res_den !== oldest.den) begin
                    mismatches++;
                    $display("%0t: res_den expected %0d got %0d",
                             $time, oldest.den, out_ch.res_den);
                end
                if (out_ch.bad_gcd !== oldest.bad) begin
                    mismatches++;
                    $display("%0t: bad_gcd expected %0b got %0b",
                             $time, oldest.bad, out_ch.bad_gcd);
                end
            end
        end
    end

    // hang guard
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
